### hdl/pfvt_pkg.sv
`timescale 1ns / 1ps

package pfvt_pkg;

    localparam logic [5:0] VER_NONE = 6'd32;

    typedef enum logic [1:0] {
        ST_UNINIT = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_VALID  = 2'd2
    } slot_status_t;

    typedef enum logic [2:0] {
        REJ_NONE       = 3'd0,
        REJ_MALFORMED  = 3'd1,
        REJ_VER_LOST   = 3'd2,
        REJ_EMPTY_DUP  = 3'd3,
        REJ_OTHER_DUP  = 3'd4,
        REJ_EVENT_DUP  = 3'd5
    } reject_code_t;

    typedef struct packed {
        logic [15:0] evt_ident;
        logic [31:0] start_sec;
        logic [31:0] stop_sec;
        logic [2:0]  run_state;
        logic        ca_mode;
    } event_t;

    typedef struct packed {
        logic [7:0] sect_no;
        logic [7:0] last_sect_no;
        logic [7:0] segment_last_section;
        logic [4:0] version_number;
        logic [7:0] num_events;
        logic       actual;
        event_t     evt;
    } section_t;

    typedef struct packed {
        logic         accepted;
        reject_code_t reject_code;
        logic         ver_changed;
        logic         change_complete;
        logic         status_changed;
    } result_t;

    typedef struct packed {
        logic                    table_valid;
        logic [5:0]              tbl_ver;
        slot_status_t [1:0]      slot_status;
        logic [1:0][5:0]         slot_version;
        event_t [1:0]            slot_event;
    } table_t;

    typedef struct packed {
        logic         store;
        logic         slot;
        logic         inval;
        slot_status_t status;
        logic [5:0]   version;
        event_t       evt;
    } update_t;

endpackage

### hdl/pfvt_decide.sv
`timescale 1ns / 1ps

module pfvt_decide (
    input  pfvt_pkg::section_t sec,
    input  pfvt_pkg::table_t   tbl,
    output pfvt_pkg::result_t  res,
    output pfvt_pkg::update_t  upd
);

    logic                   malformed;
    logic                   slot;
    logic [5:0]             ver_ext;
    logic [4:0]             ver_succ;
    logic                   next_ver;
    logic                   same_ver;
    logic                   evt_match;
    logic                   inval;
    pfvt_pkg::slot_status_t cur_status;
    pfvt_pkg::slot_status_t eff_status;
    logic [5:0]             eff_ver_cur;
    logic [5:0]             eff_ver_oth;
    pfvt_pkg::reject_code_t reject;

    assign malformed = (sec.sect_no > 8'd1) || (sec.last_sect_no > 8'd1)
                    || (sec.num_events > 8'd1)
                    || (sec.sect_no > sec.last_sect_no)
                    || (sec.segment_last_section != sec.last_sect_no);

    assign slot       = sec.sect_no[0];
    assign ver_ext    = {1'b0, sec.version_number};
    assign ver_succ   = tbl.tbl_ver[4:0] + 5'd1;
    assign next_ver   = (ver_succ == sec.version_number);
    assign same_ver   = (tbl.tbl_ver == ver_ext);
    assign cur_status = tbl.slot_status[slot];
    assign evt_match  = (tbl.slot_event[slot] == sec.evt);

    always_comb begin
        reject = pfvt_pkg::REJ_NONE;
        inval  = 1'b0;
        priority if (malformed) begin
            reject = pfvt_pkg::REJ_MALFORMED;
        end else if (tbl.table_valid && tbl.tbl_ver == pfvt_pkg::VER_NONE) begin
            reject = pfvt_pkg::REJ_VER_LOST;
        end else if (tbl.table_valid && cur_status != pfvt_pkg::ST_UNINIT) begin
            priority if (next_ver) begin
                inval = 1'b1;
            end else if (same_ver) begin
                priority if (sec.num_events == 8'd0) begin
                    priority if (cur_status == pfvt_pkg::ST_EMPTY) begin
                        reject = pfvt_pkg::REJ_EMPTY_DUP;
                    end else if (!sec.actual) begin
                        reject = pfvt_pkg::REJ_OTHER_DUP;
                    end else begin
                        inval = 1'b1;
                    end
                end else if (cur_status == pfvt_pkg::ST_VALID && evt_match) begin
                    reject = pfvt_pkg::REJ_EVENT_DUP;
                end else begin
                    inval = 1'b0;
                end
            end else begin
                inval = 1'b0;
            end
        end else begin
            inval = 1'b0;
        end
    end

    // slot view after a possible invalidation
    assign eff_status  = inval ? pfvt_pkg::ST_UNINIT : cur_status;
    assign eff_ver_cur = inval ? pfvt_pkg::VER_NONE : tbl.slot_version[slot];
    assign eff_ver_oth = inval ? pfvt_pkg::VER_NONE : tbl.slot_version[~slot];

    always_comb begin
        res = '0;
        res.reject_code = reject;
        if (reject == pfvt_pkg::REJ_NONE) begin
            res.accepted        = 1'b1;
            res.ver_changed     = (eff_ver_cur != ver_ext);
            res.change_complete = (eff_ver_oth == ver_ext);
            res.status_changed  = (eff_status == pfvt_pkg::ST_VALID)
                               && (tbl.slot_event[slot].run_state
                                   != sec.evt.run_state);
        end
    end

    assign upd.store   = (reject == pfvt_pkg::REJ_NONE);
    assign upd.slot    = slot;
    assign upd.inval   = inval;
    assign upd.status  = (sec.num_events != 8'd0) ? pfvt_pkg::ST_VALID : pfvt_pkg::ST_EMPTY;
    assign upd.version = ver_ext;
    assign upd.evt     = sec.evt;

endmodule

### hdl/pfvt_table.sv
`timescale 1ns / 1ps

module pfvt_table (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  pfvt_pkg::update_t upd,
    output pfvt_pkg::table_t  tbl
);

    logic                            table_valid_reg, table_valid_next;
    logic [5:0]                      tbl_ver_reg, tbl_ver_next;
    pfvt_pkg::slot_status_t [1:0]    slot_status_reg, slot_status_next;
    logic [1:0][5:0]                 slot_version_reg, slot_version_next;
    pfvt_pkg::event_t [1:0]          slot_event_reg;

    always_comb begin
        table_valid_next   = table_valid_reg;
        tbl_ver_next       = tbl_ver_reg;
        slot_status_next   = slot_status_reg;
        slot_version_next  = slot_version_reg;
        if (en && upd.store) begin
            if (upd.inval) begin
                slot_status_next[~upd.slot]  = pfvt_pkg::ST_UNINIT;
                slot_version_next[~upd.slot] = pfvt_pkg::VER_NONE;
            end
            table_valid_next              = 1'b1;
            tbl_ver_next                  = upd.version;
            slot_status_next[upd.slot]    = upd.status;
            slot_version_next[upd.slot]   = upd.version;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_valid_reg   <= 1'b0;
            tbl_ver_reg       <= pfvt_pkg::VER_NONE;
            slot_status_reg   <= '{pfvt_pkg::ST_UNINIT, pfvt_pkg::ST_UNINIT};
            slot_version_reg  <= {pfvt_pkg::VER_NONE, pfvt_pkg::VER_NONE};
        end else begin
            table_valid_reg   <= table_valid_next;
            tbl_ver_reg       <= tbl_ver_next;
            slot_status_reg   <= slot_status_next;
            slot_version_reg  <= slot_version_next;
        end
    end

    // event data is only looked at while its slot is valid
    always_ff @(posedge aclk) begin
        if (en && upd.store) begin
            slot_event_reg[upd.slot] <= upd.evt;
        end
    end

    assign tbl.table_valid   = table_valid_reg;
    assign tbl.tbl_ver       = tbl_ver_reg;
    assign tbl.slot_status   = slot_status_reg;
    assign tbl.slot_version  = slot_version_reg;
    assign tbl.slot_event    = slot_event_reg;

endmodule

### hdl/pf_section_version_tracker_top.sv
`timescale 1ns / 1ps
// channel | ports      | handshake         | carries
// input   | s_*        | s_valid / s_ready | section header and first event
// result  | m_*        | m_valid / m_ready | verdict and change flags
//
// one word per cycle each way unless the result stalls; a result reaches the
// m_ ports through the input register, then the result register
// the table state is updated as a word moves from the input register to the
// result register, so the following word already sees it
// synchronous active-low reset clears valid flags, slot status, versions
// a stalled result holds the input register; s_ready then follows m_ready

module pf_section_version_tracker_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_section_number,
    input  logic [7:0]  s_last_section_number,
    input  logic [7:0]  s_segment_last_section,
    input  logic [4:0]  s_version_number,
    input  logic [7:0]  s_event_count,
    input  logic        s_actual,
    input  logic [15:0] s_event_id,
    input  logic [31:0] s_start_time,
    input  logic [31:0] s_end_time,
    input  logic [2:0]  s_running_status,
    input  logic        s_is_scrambled,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_accepted,
    output logic [2:0]  m_reject_code,
    output logic        m_version_changed,
    output logic        m_change_complete,
    output logic        m_status_changed
);

    logic               in_valid_reg, in_valid_next;
    pfvt_pkg::section_t in_word_reg;
    logic               out_valid_reg, out_valid_next;
    pfvt_pkg::result_t  out_word_reg;
    logic               advance;
    pfvt_pkg::table_t   tbl;
    pfvt_pkg::result_t  res;
    pfvt_pkg::update_t  upd;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg.sect_no              <= s_section_number;
            in_word_reg.last_sect_no         <= s_last_section_number;
            in_word_reg.segment_last_section <= s_segment_last_section;
            in_word_reg.version_number       <= s_version_number;
            in_word_reg.num_events           <= s_event_count;
            in_word_reg.actual               <= s_actual;
            in_word_reg.evt.evt_ident        <= s_event_id;
            in_word_reg.evt.start_sec        <= s_start_time;
            in_word_reg.evt.stop_sec         <= s_end_time;
            in_word_reg.evt.run_state        <= s_running_status;
            in_word_reg.evt.ca_mode          <= s_is_scrambled;
        end
        if (advance) begin
            out_word_reg <= res;
        end
    end

    pfvt_decide u_decide (
        .sec (in_word_reg),
        .tbl (tbl),
        .res (res),
        .upd (upd)
    );

    pfvt_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (advance),
        .upd     (upd),
        .tbl     (tbl)
    );

    assign m_valid           = out_valid_reg;
    assign m_accepted        = out_word_reg.accepted;
    assign m_reject_code     = out_word_reg.reject_code;
    assign m_version_changed = out_word_reg.ver_changed;
    assign m_change_complete = out_word_reg.change_complete;
    assign m_status_changed  = out_word_reg.status_changed;

endmodule
